// ----- rtl/ils_pkg.sv -----
`default_nettype none

package ils_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int ITEM_W   = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = 12;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ITEM_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic                empty_res;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic [ITEM_W-1:0]   data;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/indexed_list_store_unit.sv -----
`default_nettype none

// Ordered list store of up to CAPACITY signed 64-bit items.
// Commands arrive as items on the s_axis channel: tdata holds command,
// position and item. Each command produces exactly one result item on the
// m_axis channel carrying data, status, count after the command and an
// empty flag. The list lives in one synchronous memory with one write port
// and one registered read port.
// A set, clear, unused code, refused command or insert at the end of the
// list goes from acceptance straight to the result in S_DONE. A get reads
// the memory and captures the entry in S_GET. An insert at position p below
// the count n passes S_INS and S_INS_LAST, a remove passes S_REM0 and,
// unless p is the last entry, S_REM; the shift moves one entry per cycle.
// The next command is accepted once the previous result has moved into the
// output register, even while that result still waits for m_axis_tready.
// If the receiver stalls with a result already waiting, the sequencer holds
// its finished result and accepts nothing more until the register frees.
// Reset empties the list; memory contents are not cleared and need no pass.

module indexed_list_store_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: command[2:0], position[8:3], item[72:9], zero fill.
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: data[63:0], status[65:64], count[72:66],
    // empty_res[73], zero fill.
    output logic [79:0]      m_axis_tdata
);
    import ils_pkg::*;

    t_mem_req          mem_req;
    logic [ITEM_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_ready;
    t_result           res;

    logic    r_out_valid;
    t_result r_out;

    ils_mem #(
        .CAPACITY(CAPACITY)
    ) u_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(mem_rdata)
    );

    ils_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_command  (s_axis_tdata[2:0]),
        .i_position (s_axis_tdata[8:3]),
        .i_item     (s_axis_tdata[72:9]),
        .o_mem_req  (mem_req),
        .i_rdata    (mem_rdata),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

endmodule

`default_nettype wire

// ----- rtl/ils_mem.sv -----
`default_nettype none

module ils_mem #(
    parameter int CAPACITY = 64
) (
    input  wire logic                    i_clk,
    input  wire ils_pkg::t_mem_req       i_req,
    output logic [ils_pkg::ITEM_W-1:0]   o_rdata
);
    import ils_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [ITEM_W-1:0] r_mem [CAPACITY];
    logic [ITEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/ils_ctrl.sv -----
`default_nettype none

module ils_ctrl #(
    parameter int CAPACITY = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [ils_pkg::CMD_W-1:0]  i_command,
    input  wire logic [ils_pkg::POS_W-1:0]  i_position,
    input  wire logic [ils_pkg::ITEM_W-1:0] i_item,
    output ils_pkg::t_mem_req             o_mem_req,
    input  wire logic [ils_pkg::ITEM_W-1:0] i_rdata,
    output logic                          o_res_valid,
    input  wire logic                     i_res_ready,
    output ils_pkg::t_result              o_res
);
    import ils_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_LAST = 3'd2;
    localparam logic [2:0] S_REM0     = 3'd3;
    localparam logic [2:0] S_REM      = 3'd4;
    localparam logic [2:0] S_GET      = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_addr, n_addr;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [ITEM_W-1:0]   r_item, n_item;
    logic [ITEM_W-1:0]   r_data, n_data;
    logic [STATUS_W-1:0] r_status, n_status;

    logic          accept;
    logic [XW-1:0] in_pos_x;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] addr_x;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign in_pos_x = XW'(i_position);
    assign pos_x    = XW'(r_pos);
    assign cnt_x    = XW'(r_count);
    assign addr_x   = XW'(r_addr);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_pos     = r_pos;
        n_item    = r_item;
        n_data    = r_data;
        n_status  = r_status;
        o_mem_req = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pos    = i_position;
                    n_item   = i_item;
                    n_data   = '0;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    case (i_command)
                        CMD_INSERT: begin
                            if (in_pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (in_pos_x == cnt_x) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = ADDR_W'(in_pos_x);
                                o_mem_req.wdata = i_item;
                                n_count         = r_count + CW'(1);
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = ADDR_W'(r_count - CW'(1));
                                n_addr          = AW'(r_count - CW'(1));
                                n_state         = S_INS;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (in_pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = ADDR_W'(in_pos_x);
                                n_state         = S_REM0;
                            end
                        end
                        CMD_GET: begin
                            if (in_pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = ADDR_W'(in_pos_x);
                                n_state         = S_GET;
                            end
                        end
                        CMD_SET: begin
                            if (in_pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = ADDR_W'(in_pos_x);
                                o_mem_req.wdata = i_item;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = ADDR_W'(addr_x + XW'(1));
                o_mem_req.wdata = i_rdata;
                if (addr_x == pos_x) begin
                    n_state = S_INS_LAST;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = ADDR_W'(r_addr - AW'(1));
                    n_addr          = r_addr - AW'(1);
                end
            end
            S_INS_LAST: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = ADDR_W'(pos_x);
                o_mem_req.wdata = r_item;
                n_count         = r_count + CW'(1);
                n_state         = S_DONE;
            end
            S_REM0: begin
                n_data = i_rdata;
                if (pos_x + XW'(1) < cnt_x) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = ADDR_W'(pos_x + XW'(1));
                    n_addr          = AW'(pos_x + XW'(1));
                    n_state         = S_REM;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_REM: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = ADDR_W'(addr_x - XW'(1));
                o_mem_req.wdata = i_rdata;
                if (addr_x + XW'(1) < cnt_x) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = ADDR_W'(addr_x + XW'(1));
                    n_addr          = r_addr + AW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_GET: begin
                n_data  = i_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_addr   <= n_addr;
        r_pos    <= n_pos;
        r_item   <= n_item;
        r_data   <= n_data;
        r_status <= n_status;
    end

    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.data      = r_data;
    assign o_res.status    = r_status;
    assign o_res.count     = COUNT_W'(r_count);
    assign o_res.empty_res = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("item count exceeds capacity");

    a_ins_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (addr_x >= pos_x && addr_x < cnt_x))
        else $error("insert shift address left its window");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the list");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.we && o_mem_req.re) |-> (o_mem_req.waddr != o_mem_req.raddr))
        else $error("read and write hit the same entry");

endmodule

`default_nettype wire

// ----- tb/list_store_checker.sv -----
module list_store_checker #(
    parameter int CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    // Fields from bit 0: command[2:0], position[8:3], item[72:9], zero fill.
    input  wire logic [79:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: data[63:0], status[65:64], count[72:66],
    // empty_res[73], zero fill.
    input  wire logic [79:0] m_axis_tdata,
    output int               o_pending,
    output int               o_fail_count
);
    import ils_pkg::*;

    logic [ITEM_W-1:0] mirror_list [CAPACITY];
    int                mirror_count = 0;
    t_result           awaited_results [$];
    int                fail_total = 0;

    function automatic t_result apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [POS_W-1:0] pos,
                                              input logic [ITEM_W-1:0] val);
        t_result res;
        int      p;
        p = int'(pos);
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (p > mirror_count) begin
                    res.status = ST_RANGE;
                end else if (mirror_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = mirror_count; k > p; k--) begin
                        mirror_list[k] = mirror_list[k-1];
                    end
                    mirror_list[p] = val;
                    mirror_count++;
                end
            end
            CMD_REMOVE: begin
                if (mirror_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= mirror_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = mirror_list[p];
                    for (int k = p; k + 1 < mirror_count; k++) begin
                        mirror_list[k] = mirror_list[k+1];
                    end
                    mirror_count--;
                end
            end
            CMD_GET: begin
                if (p >= mirror_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = mirror_list[p];
                end
            end
            CMD_SET: begin
                if (p >= mirror_count) begin
                    res.status = ST_RANGE;
                end else begin
                    mirror_list[p] = val;
                end
            end
            CMD_CLEAR: begin
                mirror_count = 0;
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(mirror_count);
        res.empty_res = (mirror_count == 0);
        return res;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            mirror_count = 0;
            awaited_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[73:0]);
                if (awaited_results.size() == 0) begin
                    $error("result item arrived with no command outstanding");
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("data", $signed(want.data), $signed(got.data));
                    compare_field("status", want.status, got.status);
                    compare_field("count", want.count, got.count);
                    compare_field("empty_res", want.empty_res, got.empty_res);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(apply_command(s_axis_tdata[2:0],
                                                        s_axis_tdata[8:3],
                                                        s_axis_tdata[72:9]));
            end
        end
        o_pending <= awaited_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import ils_pkg::*;

    localparam int CAPACITY = 64;
    localparam int RANDOM_ITEMS = 1650;
    localparam int POS_MAX = (1 << POS_W) - 1;
    localparam logic [ITEM_W-1:0] ITEM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ITEM_W-1:0] ITEM_MIN = 64'h8000_0000_0000_0000;
    localparam logic [ITEM_W-1:0] ALL_ONES = '1;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} t_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    int pending;
    int fail_count;
    int fill = 0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;

    indexed_list_store_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    list_store_checker #(
        .CAPACITY(CAPACITY)
    ) list_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #6_400_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int stall;
        forever begin
            stall = quiet_rx ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic [ITEM_W-1:0] val);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, val, pos, cmd};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        case (cmd)
            CMD_INSERT: begin
                if (int'(pos) <= fill && fill < CAPACITY) fill++;
            end
            CMD_REMOVE: begin
                if (fill > 0 && int'(pos) < fill) fill--;
            end
            CMD_CLEAR: begin
                fill = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic wait_list_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [ITEM_W-1:0] random_item();
        case ($urandom_range(0, 11))
            0: return ITEM_MAX;
            1: return ITEM_MIN;
            2: return '0;
            3: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input t_mode mode);
        int r;
        int ins_w;
        int rem_w;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                ins_w = 70;
                rem_w = 8;
            end
            MODE_SHRINK: begin
                ins_w = 12;
                rem_w = 55;
            end
            MODE_MIXED: begin
                ins_w = 35;
                rem_w = 30;
            end
            default: begin
                ins_w = 30;
                rem_w = 30;
            end
        endcase
        if (r < ins_w) return CMD_INSERT;
        if (r < ins_w + rem_w) return CMD_REMOVE;
        if (r < 94) return (r % 2 == 1) ? CMD_GET : CMD_SET;
        if (r < 97) return (mode == MODE_GROW) ? CMD_GET : CMD_CLEAR;
        return CMD_CLEAR + CMD_W'($urandom_range(1, 3));
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd,
                                                       input t_mode mode);
        int r;
        int top_pos;
        r = $urandom_range(0, 99);
        top_pos = (cmd == CMD_INSERT) ? fill : fill - 1;
        if (top_pos > POS_MAX) top_pos = POS_MAX;
        if (r < 8 || (mode == MODE_NOISE && r < 50) || top_pos < 0) begin
            return POS_W'($urandom_range(0, POS_MAX));
        end
        if (r < 14) return '0;
        if (r < 20) return POS_W'(top_pos);
        return POS_W'($urandom_range(0, top_pos));
    endfunction

    initial begin
        t_mode            mode;
        int               issued;
        int               span;
        bit               mid_pause_done;
        logic [CMD_W-1:0] cmd;
        issued = 0;
        mid_pause_done = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_command(CMD_REMOVE, POS_W'(POS_MAX), ITEM_MAX);
        issue_command(CMD_GET, '0, '0);
        issue_command(CMD_SET, POS_W'(5), ALL_ONES);
        issue_command(CMD_INSERT, POS_W'(1), ALL_ONES);
        issue_command(CMD_INSERT, '0, ITEM_MAX);
        issue_command(CMD_INSERT, POS_W'(1), ITEM_MIN);
        issue_command(CMD_INSERT, '0, ALL_ONES);
        issue_command(CMD_INSERT, POS_W'(4), ITEM_MAX);
        issue_command(CMD_INSERT, POS_W'(3), 64'h5555_AAAA_5555_AAAA);
        for (int p = 0; p < 4; p++) begin
            issue_command(CMD_GET, POS_W'(p), '0);
        end
        issue_command(CMD_SET, POS_W'(1), '0);
        issue_command(CMD_GET, POS_W'(4), ALL_ONES);
        issue_command(CMD_SET, POS_W'(POS_MAX), ALL_ONES);
        issue_command(CMD_REMOVE, POS_W'(4), '0);
        issue_command(CMD_REMOVE, POS_W'(1), '0);
        issue_command(CMD_REMOVE, '0, '0);
        for (int c = 1; c <= 3; c++) begin
            issue_command(CMD_CLEAR + CMD_W'(c), POS_W'(POS_MAX), ALL_ONES);
        end
        issue_command(CMD_CLEAR, '0, '0);
        issue_command(CMD_GET, '0, '0);

        wait_list_idle();

        quiet_tx = 1'b1;
        while (fill < CAPACITY) begin
            issue_command(CMD_INSERT, POS_W'($urandom_range(0, fill)), random_item());
            issued++;
        end
        quiet_tx = 1'b0;
        issue_command(CMD_INSERT, POS_W'($urandom_range(0, POS_MAX)), random_item());
        issue_command(CMD_GET, POS_W'(POS_MAX), '0);
        issue_command(CMD_SET, POS_W'(POS_MAX), random_item());
        issue_command(CMD_REMOVE, POS_W'(POS_MAX), '0);
        issue_command(CMD_REMOVE, '0, '0);
        issued += 5;

        while (issued < RANDOM_ITEMS) begin
            mode = t_mode'($urandom_range(0, 3));
            span = $urandom_range(60, 150);
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            repeat (span) begin
                cmd = pick_command(mode);
                issue_command(cmd, pick_position(cmd, mode), random_item());
            end
            issued += span;
            if (!mid_pause_done && issued > RANDOM_ITEMS / 2) begin
                wait_list_idle();
                mid_pause_done = 1'b1;
            end
        end

        wait_list_idle();
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ils_pkg.sv
rtl/ils_mem.sv
rtl/ils_ctrl.sv
rtl/indexed_list_store_unit.sv
tb/list_store_checker.sv
tb/tb_top.sv
